// File: sv/mlg_pkg.sv
// ----------------------------------------------------------------------------
// mlg_pkg
// Shared types, constants and helpers for the multilinear grid interpolator.
// ----------------------------------------------------------------------------
package mlg_pkg;

   // sizes
   localparam int MAX_DIMS   = 4;
   localparam int GRID_DEPTH = 4096;
   localparam int ADDR_W     = 12;
   localparam int VAL_W      = 24;
   localparam int FRAC_W     = 17;
   localparam int TOTAL_W    = 13;
   localparam int QUO_W      = 28;
   localparam int SUM_W      = 47;
   localparam int REQ_DATA_W = 136;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

   // register map
   localparam logic [2:0] CSR_NUM_DIMS = 3'd0;
   localparam logic [2:0] CSR_AXIS_0   = 3'd1;
   localparam logic [2:0] CSR_AXIS_3   = 3'd4;

   localparam logic [2:0]  NUM_DIMS_RESET = 3'd1;
   localparam logic [63:0] AXIS_RESET     = 64'd563018672898048;

   // one axis setup word: point count, maximum, minimum (msb first)
   typedef struct packed {
      logic [15:0]        npoints;
      logic signed [23:0] xmax;
      logic signed [23:0] xmin;
   } axis_type;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_QUERY,
      OP_BAD
   } op_kind_type;

   // one queued transaction
   typedef struct packed {
      op_kind_type              kind;
      logic [ADDR_W-1:0]        index;
      logic signed [VAL_W-1:0]  value;
      logic [3:0][VAL_W-1:0]    coord;
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AXIS_CHK,
      ST_AXIS_MUL,
      ST_AXIS_DIV,
      ST_AXIS_END,
      ST_STRIDE,
      ST_CORNER_W,
      ST_CORNER_MAC,
      ST_FINISH,
      ST_DONE
   } back_state_type;

   // highest corner number for a given axis count
   function automatic logic [3:0] corner_mask(input logic [2:0] dims);
      logic [3:0] m;
      case (dims)
         3'd1:    m = 4'h1;
         3'd2:    m = 4'h3;
         3'd3:    m = 4'h7;
         default: m = 4'hF;
      endcase
      return m;
   endfunction

endpackage

// File: sv/mlg_front.sv
// ----------------------------------------------------------------------------
// mlg_front
// Accepts transactions, unpacks them and classifies each as a store write,
// a query or a query against a bad setup, then pushes it to the queue.
// ----------------------------------------------------------------------------
module mlg_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mlg_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tuser,
   input  logic [2:0]                         num_dims,
   input  mlg_pkg::axis_type                  axis [mlg_pkg::MAX_DIMS],
   input  logic                               q_full,
   output logic                               q_push,
   output mlg_pkg::op_type                    q_op
);
   import mlg_pkg::*;

   logic bad_setup;

   // static setup check: axis count, ordering and point count per axis
   always_comb begin
      bad_setup = (num_dims == 3'd0) || (num_dims > 3'(MAX_DIMS));
      for (int k = 0; k < MAX_DIMS; k++) begin
         if (3'(k) < num_dims) begin
            if ((axis[k].xmin >= axis[k].xmax) || (axis[k].npoints < 16'd2)) begin
               bad_setup = 1'b1;
            end
         end
      end
   end

   // unpack and classify
   always_comb begin
      q_op.index    = req_tdata[11:0];
      q_op.value    = req_tdata[35:12];
      q_op.coord[0] = req_tdata[59:36];
      q_op.coord[1] = req_tdata[83:60];
      q_op.coord[2] = req_tdata[107:84];
      q_op.coord[3] = req_tdata[131:108];
      if (!req_tuser) begin
         q_op.kind = OP_WRITE;
      end else if (bad_setup) begin
         q_op.kind = OP_BAD;
      end else begin
         q_op.kind = OP_QUERY;
      end
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

// File: sv/mlg_queue.sv
// ----------------------------------------------------------------------------
// mlg_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module mlg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mlg_pkg::op_type  push_op,
   input  logic             pop,
   output mlg_pkg::op_type  head_op,
   output logic             full,
   output logic             empty
);
   import mlg_pkg::*;

   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head_op = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: sv/mlg_back.sv
// ----------------------------------------------------------------------------
// mlg_back
// Carries out queued transactions: store writes, and queries through a
// per-axis divider, a stride pass and a corner weight/accumulate loop.
// Holds the grid store and the result register.
// ----------------------------------------------------------------------------
module mlg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mlg_pkg::op_type               head_op,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  logic [2:0]                    num_dims,
   input  mlg_pkg::axis_type             axis [mlg_pkg::MAX_DIMS],
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mlg_pkg::VAL_W-1:0]     rsp_tdata,
   output logic                          rsp_tuser
);
   import mlg_pkg::*;

   back_state_type          state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [1:0]              ax_ff, ax_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [ADDR_W-1:0]       base_ff, base_in;
   logic [ADDR_W-1:0]       cell_ff [MAX_DIMS];
   logic [ADDR_W-1:0]       cell_in [MAX_DIMS];
   logic [FRAC_W-1:0]       frac_ff [MAX_DIMS];
   logic [FRAC_W-1:0]       frac_in [MAX_DIMS];
   logic [ADDR_W-1:0]       stride_ff [MAX_DIMS];
   logic [ADDR_W-1:0]       stride_in [MAX_DIMS];
   logic [23:0]             rem_ff, rem_in;
   logic [QUO_W-1:0]        low_ff, low_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [4:0]              bit_ff, bit_in;
   logic [3:0]              corner_ff, corner_in;
   logic [1:0]              step_ff, step_in;
   logic [FRAC_W-1:0]       w_ff, w_in;
   logic [ADDR_W-1:0]       flat_ff, flat_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [VAL_W-1:0]        res_ff, res_in;
   logic                    err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                    rsp_err_ff, rsp_err_in;

   // grid store
   logic signed [VAL_W-1:0] grid_mem [GRID_DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic                    mem_we;

   // working values
   axis_type                cur;
   logic signed [VAL_W-1:0] x;
   logic [1:0]              dims_m1;
   logic [23:0]             span;
   logic [28:0]             tot_prod;
   logic [35:0]             t_prod;
   logic [24:0]             r2;
   logic                    qb;
   logic [24:0]             b_prod;
   logic [24:0]             s_prod;
   logic                    sel;
   logic [FRAC_W-1:0]       wi;
   logic [33:0]             w_prod;
   logic signed [41:0]      m_prod;
   logic signed [SUM_W-1:0] rnd;

   assign cur     = axis[ax_ff];
   assign x       = op_ff.coord[ax_ff];
   assign dims_m1 = 2'(num_dims - 3'd1);
   assign span    = 24'({cur.xmax[23], cur.xmax} - {cur.xmin[23], cur.xmin});

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ax_in        = ax_ff;
      total_in     = total_ff;
      base_in      = base_ff;
      cell_in      = cell_ff;
      frac_in      = frac_ff;
      stride_in    = stride_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      corner_in    = corner_ff;
      step_in      = step_ff;
      w_in         = w_ff;
      flat_in      = flat_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;

      tot_prod = 29'(total_ff) * 29'(cur.npoints);
      t_prod   = 36'(24'(25'({x[23], x} - {cur.xmin[23], cur.xmin})))
               * 36'(12'(cur.npoints[11:0] - 12'd1));
      r2       = {rem_ff, low_ff[QUO_W-1]};
      qb       = (r2 >= {1'b0, span});
      b_prod   = 25'(base_ff) * 25'(cur.npoints[12:0]);
      s_prod   = 25'(stride_ff[ax_ff]) * 25'(cur.npoints[12:0]);
      sel      = corner_ff[step_ff];
      wi       = sel ? frac_ff[step_ff] : 17'(FRAC_ONE - frac_ff[step_ff]);
      w_prod   = 34'(w_ff) * 34'(wi);
      m_prod   = $signed({1'b0, w_ff}) * rd_data_ff;
      rnd      = (sum_ff + SUM_W'(32768)) >>> 16;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (head_op.kind)
                  OP_WRITE: begin
                     mem_we = 1'b1;
                  end
                  OP_QUERY: begin
                     op_in    = head_op;
                     ax_in    = 2'd0;
                     total_in = TOTAL_W'(1);
                     base_in  = '0;
                     sum_in   = '0;
                     state_in = ST_AXIS_CHK;
                  end
                  default: begin
                     res_in   = '0;
                     err_in   = 1'b1;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         // running grid size check
         ST_AXIS_CHK: begin
            if (tot_prod > 29'(GRID_DEPTH)) begin
               res_in   = '0;
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               total_in = tot_prod[TOTAL_W-1:0];
               state_in = ST_AXIS_MUL;
            end
         end
         // below, above or inside the axis range
         ST_AXIS_MUL: begin
            if (x <= cur.xmin) begin
               cell_in[ax_ff] = '0;
               frac_in[ax_ff] = '0;
               state_in       = ST_AXIS_END;
            end else if (x >= cur.xmax) begin
               cell_in[ax_ff] = 12'(cur.npoints[11:0] - 12'd2);
               frac_in[ax_ff] = FRAC_ONE;
               state_in       = ST_AXIS_END;
            end else begin
               rem_in   = t_prod[35:12];
               low_in   = {t_prod[11:0], 16'd0};
               quo_in   = '0;
               bit_in   = '0;
               state_in = ST_AXIS_DIV;
            end
         end
         // restoring divide, one quotient bit a cycle: cell and fraction together
         ST_AXIS_DIV: begin
            rem_in = qb ? 24'(r2 - {1'b0, span}) : r2[23:0];
            low_in = {low_ff[QUO_W-2:0], 1'b0};
            quo_in = {quo_ff[QUO_W-2:0], qb};
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'(QUO_W - 1)) begin
               cell_in[ax_ff] = quo_in[27:16];
               frac_in[ax_ff] = {1'b0, quo_in[15:0]};
               state_in       = ST_AXIS_END;
            end
         end
         // lower corner flat index, row-major
         ST_AXIS_END: begin
            base_in = 12'(b_prod + 25'(cell_ff[ax_ff]));
            if (ax_ff == dims_m1) begin
               stride_in[ax_ff] = 12'd1;
               state_in         = ST_STRIDE;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_AXIS_CHK;
            end
         end
         // strides from the fastest axis down
         ST_STRIDE: begin
            if (ax_ff == 2'd0) begin
               corner_in = '0;
               step_in   = '0;
               state_in  = ST_CORNER_W;
            end else begin
               stride_in[ax_ff - 2'd1] = 12'(s_prod);
               ax_in                   = ax_ff - 2'd1;
            end
         end
         // corner weight, one axis a cycle
         ST_CORNER_W: begin
            w_in    = (step_ff == 2'd0) ? wi : 17'((w_prod + 34'd32768) >> 16);
            flat_in = ((step_ff == 2'd0) ? base_ff : flat_ff)
                    + (sel ? stride_ff[step_ff] : 12'd0);
            if (step_ff == dims_m1) begin
               state_in = ST_CORNER_MAC;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         // weight times corner value
         ST_CORNER_MAC: begin
            sum_in = sum_ff + SUM_W'(m_prod);
            if (corner_ff == corner_mask(num_dims)) begin
               state_in = ST_FINISH;
            end else begin
               corner_in = corner_ff + 4'd1;
               step_in   = '0;
               state_in  = ST_CORNER_W;
            end
         end
         // round and saturate
         ST_FINISH: begin
            if (rnd > SUM_W'(8388607)) begin
               res_in = 24'h7FFFFF;
            end else if (rnd < -SUM_W'(8388608)) begin
               res_in = 24'h800000;
            end else begin
               res_in = rnd[23:0];
            end
            err_in   = 1'b0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ax_ff       <= ax_in;
      total_ff    <= total_in;
      base_ff     <= base_in;
      cell_ff     <= cell_in;
      frac_ff     <= frac_in;
      stride_ff   <= stride_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      quo_ff      <= quo_in;
      bit_ff      <= bit_in;
      corner_ff   <= corner_in;
      step_ff     <= step_in;
      w_ff        <= w_in;
      flat_ff     <= flat_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // grid store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[head_op.index] <= head_op.value;
      end
      rd_data_ff <= grid_mem[flat_in];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// File: sv/multilinear_grid_interpolator_top.sv
// ----------------------------------------------------------------------------
// multilinear_grid_interpolator_top
// Multilinear interpolation over a regular grid of one to four axes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | content
//  req_    | in  | tvalid / tready   | tuser mode, tdata index, value, coords
//  rsp_    | out | tvalid / tready   | tuser setup error, tdata interp value
//  csr_    | in  | valid / ready     | index, 64-bit data, always ready
//
//  A store write is carried out as the idle back end pops it from the queue.
//  A query runs, per axis, a grid size check, a clamp or a one-bit-a-cycle
//  divide and the corner index step, then the strides, then per corner a weight
//  pass and a multiply-accumulate on the single store read port, then rounding.
//  A two-entry queue lets the front accept while the back works or stalls.
//  Reset is synchronous; the grid store is not cleared.
// ----------------------------------------------------------------------------
module multilinear_grid_interpolator_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // entry_index, entry_value, coord_0, coord_1, coord_2, coord_3, zero pad
   input  logic [135:0]  req_tdata,
   // mode
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // interp_value
   output logic [23:0]   rsp_tdata,
   // setup_error
   output logic          rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_data
);
   import mlg_pkg::*;

   logic [2:0]  num_dims_ff;
   logic [63:0] axis_ff [MAX_DIMS];
   axis_type    axis [MAX_DIMS];
   op_type      push_op, head_op;
   logic        q_push, q_pop, q_full, q_empty;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= NUM_DIMS_RESET;
         for (int k = 0; k < MAX_DIMS; k++) begin
            axis_ff[k] <= AXIS_RESET;
         end
      end else if (csr_valid) begin
         if (csr_index == CSR_NUM_DIMS) begin
            num_dims_ff <= csr_data[2:0];
         end else if ((csr_index >= CSR_AXIS_0) && (csr_index <= CSR_AXIS_3)) begin
            axis_ff[2'(csr_index - CSR_AXIS_0)] <= csr_data;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         axis[k] = axis_type'(axis_ff[k]);
      end
   end

   mlg_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .num_dims   (num_dims_ff),
      .axis       (axis),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (push_op)
   );

   mlg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .pop     (q_pop),
      .head_op (head_op),
      .full    (q_full),
      .empty   (q_empty)
   );

   mlg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_op    (head_op),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .num_dims   (num_dims_ff),
      .axis       (axis),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: sv/mlg_checker.sv
// ----------------------------------------------------------------------------
// mlg_checker
// Port-level checks for the multilinear grid interpolator, bound to the top.
// ----------------------------------------------------------------------------
module mlg_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [23:0]  rsp_tdata,
   input logic         rsp_tuser,
   input logic         csr_ready
);

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a setup error always carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("setup error with non-zero value");

   // configuration port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

   // input side can only stall while work is queued, never out of reset
   a_req_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind multilinear_grid_interpolator_top mlg_checker u_mlg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_ready  (csr_ready)
);
